[design/http_head_tokenizer_unit_macros.svh]
// ----------------------------------------------------------------------------
// HTTP head tokenizer assertion macros
// Shared wrappers for the concurrent checks on the tokenizer ports.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEAD_TOKENIZER_UNIT_MACROS_SVH
`define HTTP_HEAD_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define HHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define HHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/hht_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP head tokenizer package
// Parser mode codes, byte class codes, delimiters and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package hht_pkg;

	// Parser mode codes; 13 to 15 are unused and behave like the done mode.
	localparam int unsigned ModeW = 4;
	typedef logic [ModeW-1:0] mode_t;

	localparam mode_t M_FIRST   = 4'd0;
	localparam mode_t M_URI     = 4'd1;
	localparam mode_t M_REQVER  = 4'd2;
	localparam mode_t M_RESPVER = 4'd3;
	localparam mode_t M_STATUS  = 4'd4;
	localparam mode_t M_REASON  = 4'd5;
	localparam mode_t M_LINELF  = 4'd6;
	localparam mode_t M_HOS     = 4'd7;
	localparam mode_t M_HNAME   = 4'd8;
	localparam mode_t M_HSKIP   = 4'd9;
	localparam mode_t M_HVAL    = 4'd10;
	localparam mode_t M_SEP     = 4'd11;
	localparam mode_t M_DONE    = 4'd12;

	// Byte class codes.
	typedef logic [3:0] cls_t;
	localparam cls_t C_NONE    = 4'd0;
	localparam cls_t C_METHOD  = 4'd1;
	localparam cls_t C_URI     = 4'd2;
	localparam cls_t C_VERSION = 4'd3;
	localparam cls_t C_STATUS  = 4'd4;
	localparam cls_t C_REASON  = 4'd5;
	localparam cls_t C_HNAME   = 4'd6;
	localparam cls_t C_HVALUE  = 4'd7;
	localparam cls_t C_UNDEC   = 4'd8;

	// Field end codes share the class numbering in three bits.
	typedef logic [2:0] fend_t;
	localparam fend_t F_NONE    = 3'd0;
	localparam fend_t F_METHOD  = 3'd1;
	localparam fend_t F_URI     = 3'd2;
	localparam fend_t F_VERSION = 3'd3;
	localparam fend_t F_STATUS  = 3'd4;
	localparam fend_t F_REASON  = 3'd5;
	localparam fend_t F_HNAME   = 3'd6;
	localparam fend_t F_HVALUE  = 3'd7;

	// Message kind codes.
	typedef logic [1:0] kind_t;
	localparam kind_t K_UNKNOWN  = 2'd0;
	localparam kind_t K_REQUEST  = 2'd1;
	localparam kind_t K_RESPONSE = 2'd2;

	// Delimiter bytes.
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		mode_t mode;
		kind_t kind;
	} state_t;

	// Tagged result of one byte.
	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
		fend_t      fend;
		kind_t      kind;
		logic       done;
		logic       ferr;
	} result_t;

endpackage

`default_nettype wire

[design/http_head_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// HTTP head tokenizer
// Tags each byte of an HTTP/1.1 message head with the field it belongs to.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, data_byte, new_message) takes one
// byte per beat; new_message set on a beat restarts parsing at that byte.
// The output channel (out_valid, out_ready, out_byte ... framing_error)
// gives exactly one tagged beat for every input beat, in order.
// A beat is captured in the input register, then decoded against the parser
// state into the result register. Throughput is one byte per cycle while the
// receiver takes each result; the parser state updates in the same cycle
// that a byte moves into the result register, so each byte sees the state
// left by the one before it.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready falls only once both are occupied.
// Reset clears both valid flags and puts the parser into first-token mode
// with an unknown message kind.
// ----------------------------------------------------------------------------
`default_nettype none

module http_head_tokenizer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       new_message,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] out_byte,
	output      logic [3:0] byte_class,
	output      logic [2:0] field_end,
	output      logic [1:0] message_kind,
	output      logic       headers_done,
	output      logic       framing_error
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             newmsg_s1;
	logic             valid_s2;
	hht_pkg::result_t res_s2;
	hht_pkg::state_t  state_q;
	hht_pkg::state_t  state_d;
	hht_pkg::result_t res_d;
	logic             adv_s2;
	logic             adv_s1;

	// Stage handshakes: the result register frees when taken or empty.
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	// Input and result register valid flags and parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{mode: hht_pkg::M_FIRST, kind: hht_pkg::K_UNKNOWN};
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_d;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1   <= data_byte;
			newmsg_s1 <= new_message;
		end
	end

	// Byte decode against the current parser state.
	hht_decode u_decode (
		.data_byte   (data_s1),
		.new_message (newmsg_s1),
		.st_cur      (state_q),
		.st_nxt      (state_d),
		.res         (res_d)
	);

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign out_byte      = res_s2.data;
	assign byte_class    = res_s2.cls;
	assign field_end     = res_s2.fend;
	assign message_kind  = res_s2.kind;
	assign headers_done  = res_s2.done;
	assign framing_error = res_s2.ferr;

endmodule

`default_nettype wire

[design/hht_decode.sv]
// ----------------------------------------------------------------------------
// HTTP head tokenizer byte decoder
// Classifies one byte against the current parser state and gives the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module hht_decode (
	input  wire logic [7:0]      data_byte,
	input  wire logic            new_message,
	input  wire hht_pkg::state_t st_cur,
	output hht_pkg::state_t      st_nxt,
	output hht_pkg::result_t     res
);

	hht_pkg::mode_t   mode;
	hht_pkg::mode_t   mode_n;
	hht_pkg::kind_t   kind_n;
	hht_pkg::cls_t    cls;
	hht_pkg::fend_t   fend;
	logic             done;
	logic             ferr;

	// A new message restarts the parser before this byte is handled.
	always_comb begin
		mode   = new_message ? hht_pkg::M_FIRST : st_cur.mode;
		kind_n = new_message ? hht_pkg::K_UNKNOWN : st_cur.kind;
		mode_n = mode;
		cls    = hht_pkg::C_NONE;
		fend   = hht_pkg::F_NONE;
		done   = 1'b0;
		ferr   = 1'b0;

		unique case (mode)
			hht_pkg::M_FIRST: begin
				if (data_byte == hht_pkg::CH_SP) begin
					fend   = hht_pkg::F_METHOD;
					kind_n = hht_pkg::K_REQUEST;
					mode_n = hht_pkg::M_URI;
				end else if (data_byte == hht_pkg::CH_SLASH) begin
					cls    = hht_pkg::C_VERSION;
					kind_n = hht_pkg::K_RESPONSE;
					mode_n = hht_pkg::M_RESPVER;
				end else begin
					cls = hht_pkg::C_UNDEC;
				end
			end
			hht_pkg::M_URI: begin
				if (data_byte == hht_pkg::CH_SP) begin
					fend   = hht_pkg::F_URI;
					mode_n = hht_pkg::M_REQVER;
				end else begin
					cls = hht_pkg::C_URI;
				end
			end
			hht_pkg::M_REQVER: begin
				if (data_byte == hht_pkg::CH_CR) begin
					fend   = hht_pkg::F_VERSION;
					mode_n = hht_pkg::M_LINELF;
				end else if (data_byte == hht_pkg::CH_LF) begin
					mode_n = hht_pkg::M_HOS;
				end else begin
					cls = hht_pkg::C_VERSION;
				end
			end
			hht_pkg::M_RESPVER: begin
				if (data_byte == hht_pkg::CH_SP) begin
					fend   = hht_pkg::F_VERSION;
					mode_n = hht_pkg::M_STATUS;
				end else begin
					cls = hht_pkg::C_VERSION;
				end
			end
			hht_pkg::M_STATUS: begin
				if (data_byte == hht_pkg::CH_SP) begin
					fend   = hht_pkg::F_STATUS;
					mode_n = hht_pkg::M_REASON;
				end else begin
					cls = hht_pkg::C_STATUS;
				end
			end
			hht_pkg::M_REASON: begin
				if (data_byte == hht_pkg::CH_CR) begin
					fend   = hht_pkg::F_REASON;
					mode_n = hht_pkg::M_LINELF;
				end else if (data_byte == hht_pkg::CH_LF) begin
					mode_n = hht_pkg::M_HOS;
				end else begin
					cls = hht_pkg::C_REASON;
				end
			end
			hht_pkg::M_LINELF: begin
				if (data_byte == hht_pkg::CH_LF) begin
					mode_n = hht_pkg::M_HOS;
				end
			end
			hht_pkg::M_HOS: begin
				if (data_byte == hht_pkg::CH_CR) begin
					mode_n = hht_pkg::M_SEP;
				end else if (data_byte == hht_pkg::CH_COLON) begin
					fend   = hht_pkg::F_HNAME;
					mode_n = hht_pkg::M_HSKIP;
				end else begin
					cls    = hht_pkg::C_HNAME;
					mode_n = hht_pkg::M_HNAME;
				end
			end
			hht_pkg::M_HNAME: begin
				if (data_byte == hht_pkg::CH_COLON) begin
					fend   = hht_pkg::F_HNAME;
					mode_n = hht_pkg::M_HSKIP;
				end else begin
					cls = hht_pkg::C_HNAME;
				end
			end
			hht_pkg::M_HSKIP, hht_pkg::M_HVAL: begin
				// Leading spaces of a value get no class; later spaces are value bytes.
				if (data_byte == hht_pkg::CH_SP && mode == hht_pkg::M_HSKIP) begin
					mode_n = hht_pkg::M_HSKIP;
				end else if (data_byte == hht_pkg::CH_CR) begin
					fend   = hht_pkg::F_HVALUE;
					mode_n = hht_pkg::M_LINELF;
				end else if (data_byte == hht_pkg::CH_LF) begin
					mode_n = hht_pkg::M_HOS;
				end else begin
					cls    = hht_pkg::C_HVALUE;
					mode_n = hht_pkg::M_HVAL;
				end
			end
			hht_pkg::M_SEP: begin
				if (data_byte == hht_pkg::CH_LF) begin
					done   = 1'b1;
					mode_n = hht_pkg::M_DONE;
				end else begin
					ferr = 1'b1;
				end
			end
			default: begin
				// Done mode and the unused codes ignore every byte.
				mode_n = mode;
			end
		endcase
	end

	assign st_nxt.mode = mode_n;
	assign st_nxt.kind = kind_n;

	assign res.data = data_byte;
	assign res.cls  = cls;
	assign res.fend = fend;
	assign res.kind = kind_n;
	assign res.done = done;
	assign res.ferr = ferr;

endmodule

`default_nettype wire

[design/hht_checker.sv]
// ----------------------------------------------------------------------------
// HTTP head tokenizer port checker
// Watches the tokenizer ports for tagging and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_head_tokenizer_unit_macros.svh"

module hht_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic [3:0] byte_class,
	input wire logic [2:0] field_end,
	input wire logic [1:0] message_kind,
	input wire logic       headers_done,
	input wire logic       framing_error
);

	// A stalled result beat keeps its valid, byte, class and field end.
	`HHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_class) && $stable(field_end), "result beat changed while stalled")

	// A byte that closes a field is itself a delimiter.
	`HHT_ASSERT_NOW(a_end_is_delim, out_valid && field_end != hht_pkg::F_NONE, byte_class == hht_pkg::C_NONE, "closing byte carries a field class")

	// The end of the head is marked only on a plain LF.
	`HHT_ASSERT_NOW(a_done_on_lf, out_valid && headers_done, out_byte == hht_pkg::CH_LF && byte_class == hht_pkg::C_NONE && !framing_error, "headers done on a wrong byte")

	// A framing error is never an LF and never tagged.
	`HHT_ASSERT_NOW(a_ferr_not_lf, out_valid && framing_error, out_byte != hht_pkg::CH_LF && byte_class == hht_pkg::C_NONE && field_end == hht_pkg::F_NONE, "framing error on LF or tagged byte")

	// Method bytes are tagged undecided, and kind code three does not exist.
	`HHT_ASSERT_NOW(a_codes, out_valid, byte_class != hht_pkg::C_METHOD && byte_class <= hht_pkg::C_UNDEC && message_kind != 2'd3, "class or kind code out of range")

endmodule

bind http_head_tokenizer_unit hht_checker u_hht_checker (.*);

`default_nettype wire
